@@ hw/rtl/bua_pkg.sv @@
// Package for the bilinear upscale and alpha blend block.
// Holds sizes, configuration register indexes and shared types. No dependencies.
package bua_pkg;

    localparam int SMALL_MAX_WIDTH  = 256;
    localparam int SMALL_MAX_HEIGHT = 256;
    localparam int COORD_BITS       = 12;
    localparam int XW               = $clog2(SMALL_MAX_WIDTH);
    localparam int YW               = $clog2(SMALL_MAX_HEIGHT);
    localparam int CFG_IDX_BITS     = 3;
    localparam int CFG_DATA_BITS    = 17;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SMALL_WIDTH  = 3'd0,
        CFG_SMALL_HEIGHT = 3'd1,
        CFG_COL_STEP     = 3'd2,
        CFG_ROW_STEP     = 3'd3,
        CFG_BLEND_WEIGHT = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_BLEND = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Input word.
    typedef struct packed {
        logic                  cmd;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [7:0]            red_in;
        logic [7:0]            green_in;
        logic [7:0]            blue_in;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [COORD_BITS-1:0] out_col;
        logic [COORD_BITS-1:0] out_row;
        logic [7:0]            red_out;
        logic [7:0]            green_out;
        logic [7:0]            blue_out;
    } t_out_word;

endpackage

@@ hw/rtl/bua_stream_if.sv @@
// Valid/ready stream interface used for both the input and result channels.
// Depends on nothing; the payload type is a parameter.
interface bua_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/bua_store.sv @@
// Four-bank small frame store, one bank per x/y parity, registered reads.
// Depends on bua_pkg.
module bua_store (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [bua_pkg::XW-1:0]    i_wx,
    input  logic [bua_pkg::YW-1:0]    i_wy,
    input  bua_pkg::t_rgb             i_wdata,
    input  logic                      i_re,
    input  logic [bua_pkg::XW-1:0]    i_x0,
    input  logic [bua_pkg::XW-1:0]    i_x1,
    input  logic [bua_pkg::YW-1:0]    i_y0,
    input  logic [bua_pkg::YW-1:0]    i_y1,
    output bua_pkg::t_rgb             o_p00,
    output bua_pkg::t_rgb             o_p01,
    output bua_pkg::t_rgb             o_p10,
    output bua_pkg::t_rgb             o_p11
);
    import bua_pkg::*;

    localparam int BX = XW - 1;
    localparam int BY = YW - 1;
    localparam int BD = 1 << (BX + BY);

    // Bank b = {y parity, x parity}; each bank holds every other column and row.
    t_rgb r_bank0 [BD];
    t_rgb r_bank1 [BD];
    t_rgb r_bank2 [BD];
    t_rgb r_bank3 [BD];

    logic [BX+BY-1:0] wa;
    logic [BX-1:0]    xe, xo;
    logic [BY-1:0]    ye, yo;
    logic             x0odd, y0odd;
    t_rgb             r_q0, r_q1, r_q2, r_q3;
    logic             r_x0odd, r_y0odd;
    logic             r_xsame, r_ysame;
    t_rgb             d00, d01, d10, d11;

    assign wa = {i_wy[YW-1:1], i_wx[XW-1:1]};

    // Pick the even and odd column/row among the two neighbours.
    assign x0odd = i_x0[0];
    assign y0odd = i_y0[0];
    assign xe = x0odd ? i_x1[XW-1:1] : i_x0[XW-1:1];
    assign xo = x0odd ? i_x0[XW-1:1] : i_x1[XW-1:1];
    assign ye = y0odd ? i_y1[YW-1:1] : i_y0[YW-1:1];
    assign yo = y0odd ? i_y0[YW-1:1] : i_y1[YW-1:1];

    always_ff @(posedge i_clk) begin
        if (i_we && !i_wx[0] && !i_wy[0]) r_bank0[wa] <= i_wdata;
        if (i_we &&  i_wx[0] && !i_wy[0]) r_bank1[wa] <= i_wdata;
        if (i_we && !i_wx[0] &&  i_wy[0]) r_bank2[wa] <= i_wdata;
        if (i_we &&  i_wx[0] &&  i_wy[0]) r_bank3[wa] <= i_wdata;
        if (i_re) begin
            r_q0    <= r_bank0[{ye, xe}];
            r_q1    <= r_bank1[{ye, xo}];
            r_q2    <= r_bank2[{yo, xe}];
            r_q3    <= r_bank3[{yo, xo}];
            r_x0odd <= x0odd;
            r_y0odd <= y0odd;
            r_xsame <= (i_x1 == i_x0);
            r_ysame <= (i_y1 == i_y0);
        end
    end

    // Route bank outputs back to neighbour positions. At a clamped edge the
    // second neighbour is the first one itself, so it is taken from there.
    always_comb begin
        unique case ({r_y0odd, r_x0odd})
            2'b00: begin
                d00 = r_q0; d01 = r_q1; d10 = r_q2; d11 = r_q3;
            end
            2'b01: begin
                d00 = r_q1; d01 = r_q0; d10 = r_q3; d11 = r_q2;
            end
            2'b10: begin
                d00 = r_q2; d01 = r_q3; d10 = r_q0; d11 = r_q1;
            end
            default: begin
                d00 = r_q3; d01 = r_q2; d10 = r_q1; d11 = r_q0;
            end
        endcase
        o_p00 = d00;
        o_p01 = r_xsame ? d00 : d01;
        o_p10 = r_ysame ? d00 : d10;
        o_p11 = r_xsame ? (r_ysame ? d00 : d10) : (r_ysame ? d01 : d11);
    end
endmodule

@@ hw/rtl/bilinear_upscale_alpha_blend_top.sv @@
// Top level: coordinate mapping, banked store reads, bilinear filter and blend.
// Depends on bua_pkg, bua_stream_if and bua_store.
// Pipeline: six register stages, from the coordinate products to the output register.
// Throughput: one word per cycle while the output is not stalled; the four-bank
// store serves all four neighbours in one read. Loads give no result.
// Reset (synchronous, active low) clears valid bits and restores registers;
// the frame store is not cleared and holds garbage until loaded.
module bilinear_upscale_alpha_blend_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    bua_stream_if.sink                            s_in,
    bua_stream_if.source                          m_out,
    input  logic                                  i_cfg_we,
    input  logic [bua_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [bua_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);
    import bua_pkg::*;

    localparam int NST = 6;
    localparam int CB  = COORD_BITS;

    // Configuration registers.
    logic [8:0]  r_sw, r_sh, r_bw;
    logic [16:0] r_cs, r_rs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= 9'd256; r_sh <= 9'd256; r_bw <= 9'd128;
            r_cs <= 17'd32768; r_rs <= 17'd32768;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SMALL_WIDTH:  r_sw <= i_cfg_data[8:0];
                CFG_SMALL_HEIGHT: r_sh <= i_cfg_data[8:0];
                CFG_COL_STEP:     r_cs <= i_cfg_data;
                CFG_ROW_STEP:     r_rs <= i_cfg_data;
                CFG_BLEND_WEIGHT: r_bw <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Clamped configuration values.
    logic [8:0]    wlim, hlim, bwc;
    logic [16:0]   csc, rsc;
    logic [XW-1:0] xmax;
    logic [YW-1:0] ymax;
    logic [8:0]    wm1, hm1;
    always_comb begin
        wlim = (r_sw == 9'd0) ? 9'd1 : (r_sw > 9'(SMALL_MAX_WIDTH)) ? 9'(SMALL_MAX_WIDTH) : r_sw;
        hlim = (r_sh == 9'd0) ? 9'd1 : (r_sh > 9'(SMALL_MAX_HEIGHT)) ? 9'(SMALL_MAX_HEIGHT) : r_sh;
        wm1  = wlim - 9'd1;
        hm1  = hlim - 9'd1;
        xmax = wm1[XW-1:0];
        ymax = hm1[YW-1:0];
        csc  = (r_cs > 17'd65536) ? 17'd65536 : r_cs;
        rsc  = (r_rs > 17'd65536) ? 17'd65536 : r_rs;
        bwc  = (r_bw > 9'd256) ? 9'd256 : r_bw;
    end

    // Pipeline control: a stage advances unless the output is full and stalled.
    logic [NST-1:0] r_v;
    logic           adv;
    assign adv = !r_v[NST-1] || m_out.ready;
    assign s_in.ready = adv;

    logic acc_in;
    assign acc_in = s_in.valid && adv;

    t_in_word iw;
    assign iw = s_in.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NST-2:0], acc_in && (iw.cmd == CMD_BLEND)};
        end
    end

    // Stage 1: products of coordinates and steps.
    logic [CB+16:0] r1_x, r1_y;
    logic [CB-1:0]  r_col [NST-1];
    logic [CB-1:0]  r_row [NST-1];
    t_rgb           r_lg  [NST-1];
    logic           r1_we;
    logic [XW-1:0]  r1_wx;
    logic [YW-1:0]  r1_wy;
    t_rgb           r1_wd;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_x <= iw.col * csc;
            r1_y <= iw.row * rsc;
            r_col[0] <= iw.col;
            r_row[0] <= iw.row;
            r_lg[0]  <= '{iw.red_in, iw.green_in, iw.blue_in};
            for (int i = 1; i < NST-1; i++) begin
                r_col[i] <= r_col[i-1];
                r_row[i] <= r_row[i-1];
                r_lg[i]  <= r_lg[i-1];
            end
        end
    end

    // Loads write the store as they leave the first stage, in step with the
    // pipeline, so reads and writes keep the order in which words arrived.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_we <= 1'b0;
        end else if (adv) begin
            r1_we <= acc_in && (iw.cmd == CMD_LOAD) &&
                     (iw.col < CB'(SMALL_MAX_WIDTH)) && (iw.row < CB'(SMALL_MAX_HEIGHT));
        end
        if (adv) begin
            r1_wx <= iw.col[XW-1:0];
            r1_wy <= iw.row[YW-1:0];
            r1_wd <= '{iw.red_in, iw.green_in, iw.blue_in};
        end
    end

    // Stage 2: integer parts clamped to the image, and fractions.
    logic [CB:0]   xi, yi;
    logic [XW-1:0] r2_x0, r2_x1;
    logic [YW-1:0] r2_y0, r2_y1;
    logic [7:0]    r_fx [2:NST-3];
    logic [7:0]    r_fy [2:NST-2];
    always_comb begin
        xi = r1_x[CB+16:16];
        yi = r1_y[CB+16:16];
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_x0 <= (xi > (CB+1)'(xmax)) ? xmax : xi[XW-1:0];
            r2_x1 <= (xi >= (CB+1)'(xmax)) ? xmax : xi[XW-1:0] + XW'(1);
            r2_y0 <= (yi > (CB+1)'(ymax)) ? ymax : yi[YW-1:0];
            r2_y1 <= (yi >= (CB+1)'(ymax)) ? ymax : yi[YW-1:0] + YW'(1);
            r_fx[2] <= r1_x[15:8];
            r_fy[2] <= r1_y[15:8];
            for (int i = 3; i <= NST-3; i++) begin
                r_fx[i] <= r_fx[i-1];
            end
            for (int i = 3; i <= NST-2; i++) begin
                r_fy[i] <= r_fy[i-1];
            end
        end
    end

    // Stage 3: store read (registered inside the store).
    t_rgb p00, p01, p10, p11;
    bua_store u_store (
        .i_clk  (i_clk),
        .i_we   (r1_we && adv),
        .i_wx   (r1_wx),
        .i_wy   (r1_wy),
        .i_wdata(r1_wd),
        .i_re   (adv),
        .i_x0   (r2_x0),
        .i_x1   (r2_x1),
        .i_y0   (r2_y0),
        .i_y1   (r2_y1),
        .o_p00  (p00),
        .o_p01  (p01),
        .o_p10  (p10),
        .o_p11  (p11)
    );

    // Stage 4: horizontal blend of each neighbour pair (Q.8 result, 16 bits).
    logic [8:0]  fxn, fyn;
    logic [15:0] r4_top [3];
    logic [15:0] r4_bot [3];
    logic [7:0]  a00 [3], a01 [3], a10 [3], a11 [3];
    always_comb begin
        fxn = 9'd256 - {1'b0, r_fx[NST-3]};
        a00 = '{p00.red, p00.green, p00.blue};
        a01 = '{p01.red, p01.green, p01.blue};
        a10 = '{p10.red, p10.green, p10.blue};
        a11 = '{p11.red, p11.green, p11.blue};
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                r4_top[c] <= 16'(a00[c] * fxn + a01[c] * r_fx[NST-3]);
                r4_bot[c] <= 16'(a10[c] * fxn + a11[c] * r_fx[NST-3]);
            end
        end
    end

    // Stage 5: vertical blend; exact since all weights combine into one sum.
    logic [7:0] r5_int [3];
    logic [24:0] vs [3];
    always_comb begin
        fyn = 9'd256 - {1'b0, r_fy[NST-2]};
        for (int c = 0; c < 3; c++) begin
            vs[c] = 25'(r4_top[c] * fyn) + 25'(r4_bot[c] * r_fy[NST-2]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) r5_int[c] <= vs[c][23:16];
        end
    end

    // Stage 6 and output register: alpha blend with the large pixel.
    logic [8:0] bwn;
    logic [7:0] lg [3];
    logic [16:0] bs [3];
    t_out_word r_out;
    always_comb begin
        bwn = 9'd256 - bwc;
        lg  = '{r_lg[NST-2].red, r_lg[NST-2].green, r_lg[NST-2].blue};
        for (int c = 0; c < 3; c++) begin
            bs[c] = 17'(bwc * lg[c]) + 17'(bwn * r5_int[c]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.out_col   <= r_col[NST-2];
            r_out.out_row   <= r_row[NST-2];
            r_out.red_out   <= bs[0][15:8];
            r_out.green_out <= bs[1][15:8];
            r_out.blue_out  <= bs[2][15:8];
        end
    end

    assign m_out.valid = r_v[NST-1];
    assign m_out.data  = r_out;

    // The input is held off whenever a waiting result blocks the pipeline.
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NST-1] && !m_out.ready) |-> !s_in.ready)
        else $error("input accepted while output stalled");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && !m_out.ready) |=> (m_out.valid && $stable(r_out)))
        else $error("stalled result changed");
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[1] |-> (r2_x1 <= xmax && r2_y1 <= ymax))
        else $error("neighbor out of image");
endmodule

@@ tb/bua_tb_pkg.sv @@
// Scoreboard class for the bilinear upscale and alpha blend testbench.
// Depends on bua_pkg; holds the frame-store mirror, registers and expected queue.
`timescale 1ns / 100ps
package bua_tb_pkg;
    import bua_pkg::*;

    class blend_scoreboard;
        t_rgb      frame_mirror [SMALL_MAX_WIDTH*SMALL_MAX_HEIGHT];
        bit        written      [SMALL_MAX_WIDTH*SMALL_MAX_HEIGHT];
        int unsigned reg_width, reg_height, reg_col_step, reg_row_step, reg_weight;
        t_out_word pending_pixels [$];
        int        errors;

        function new();
            reg_width    = 256;
            reg_height   = 256;
            reg_col_step = 32768;
            reg_row_step = 32768;
            reg_weight   = 128;
            errors       = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] value);
            case (idx)
                CFG_SMALL_WIDTH:  reg_width    = value[8:0];
                CFG_SMALL_HEIGHT: reg_height   = value[8:0];
                CFG_COL_STEP:     reg_col_step = value;
                CFG_ROW_STEP:     reg_row_step = value;
                CFG_BLEND_WEIGHT: reg_weight   = value[8:0];
                default: ;
            endcase
        endfunction

        // Clamped neighbor coordinates for a blend word.
        function void neighbors(input logic [COORD_BITS-1:0] col, row,
                                output int unsigned x0, x1, y0, y1, fx, fy);
            int unsigned w, h, cs, rs, x, y;
            w  = (reg_width == 0) ? 1 : (reg_width > SMALL_MAX_WIDTH ? SMALL_MAX_WIDTH
                                                                      : reg_width);
            h  = (reg_height == 0) ? 1 : (reg_height > SMALL_MAX_HEIGHT ? SMALL_MAX_HEIGHT
                                                                         : reg_height);
            cs = (reg_col_step > 65536) ? 65536 : reg_col_step;
            rs = (reg_row_step > 65536) ? 65536 : reg_row_step;
            x  = col * cs;
            y  = row * rs;
            x0 = x >> 16;
            y0 = y >> 16;
            fx = (x >> 8) & 255;
            fy = (y >> 8) & 255;
            x1 = x0 + 1;
            y1 = y0 + 1;
            if (x0 > w - 1) x0 = w - 1;
            if (x1 > w - 1) x1 = w - 1;
            if (y0 > h - 1) y0 = h - 1;
            if (y1 > h - 1) y1 = h - 1;
        endfunction

        // True when all four neighbors of this blend have been loaded.
        function bit blend_is_safe(logic [COORD_BITS-1:0] col, row);
            int unsigned x0, x1, y0, y1, fx, fy;
            neighbors(col, row, x0, x1, y0, y1, fx, fy);
            return written[y0*SMALL_MAX_WIDTH+x0] && written[y0*SMALL_MAX_WIDTH+x1] &&
                   written[y1*SMALL_MAX_WIDTH+x0] && written[y1*SMALL_MAX_WIDTH+x1];
        endfunction

        // Notes an accepted input word: loads update the mirror, blends queue a pixel.
        function void note_input(t_in_word word);
            int unsigned x0, x1, y0, y1, fx, fy, bw, acc, interp, mix;
            t_rgb p [4];
            t_out_word res;
            if (word.cmd == CMD_LOAD) begin
                if (word.col < SMALL_MAX_WIDTH && word.row < SMALL_MAX_HEIGHT) begin
                    frame_mirror[word.row*SMALL_MAX_WIDTH+word.col] =
                        {word.red_in, word.green_in, word.blue_in};
                    written[word.row*SMALL_MAX_WIDTH+word.col] = 1'b1;
                end
                return;
            end
            neighbors(word.col, word.row, x0, x1, y0, y1, fx, fy);
            bw   = (reg_weight > 256) ? 256 : reg_weight;
            p[0] = frame_mirror[y0*SMALL_MAX_WIDTH+x0];
            p[1] = frame_mirror[y0*SMALL_MAX_WIDTH+x1];
            p[2] = frame_mirror[y1*SMALL_MAX_WIDTH+x0];
            p[3] = frame_mirror[y1*SMALL_MAX_WIDTH+x1];
            res.out_col = word.col;
            res.out_row = word.row;
            for (int c = 0; c < 3; c++) begin
                int sh;
                sh     = 16 - 8*c;
                acc    = ((p[0] >> sh) & 255) * (256-fx) * (256-fy)
                       + ((p[1] >> sh) & 255) * fx * (256-fy)
                       + ((p[2] >> sh) & 255) * (256-fx) * fy
                       + ((p[3] >> sh) & 255) * fx * fy;
                interp = (acc >> 16) & 255;
                mix    = (c == 0) ? word.red_in : (c == 1) ? word.green_in : word.blue_in;
                mix    = (bw * mix + (256 - bw) * interp) >> 8;
                if (c == 0) res.red_out = mix[7:0];
                else if (c == 1) res.green_out = mix[7:0];
                else res.blue_out = mix[7:0];
            end
            pending_pixels.push_back(res);
        endfunction

        // Checks one accepted result word against the oldest expected pixel.
        function void check_result(t_out_word got);
            t_out_word exp_px;
            if (pending_pixels.size() == 0) begin
                $error("result with no pixel expected: %p", got);
                errors++;
                return;
            end
            exp_px = pending_pixels.pop_front();
            if (got.out_col !== exp_px.out_col) begin
                $error("out_col expected %0d got %0d", exp_px.out_col, got.out_col);
                errors++;
            end
            if (got.out_row !== exp_px.out_row) begin
                $error("out_row expected %0d got %0d", exp_px.out_row, got.out_row);
                errors++;
            end
            if (got.red_out !== exp_px.red_out) begin
                $error("red_out expected %0d got %0d", exp_px.red_out, got.red_out);
                errors++;
            end
            if (got.green_out !== exp_px.green_out) begin
                $error("green_out expected %0d got %0d", exp_px.green_out, got.green_out);
                errors++;
            end
            if (got.blue_out !== exp_px.blue_out) begin
                $error("blue_out expected %0d got %0d", exp_px.blue_out, got.blue_out);
                errors++;
            end
        endfunction
    endclass
endpackage

@@ tb/bilinear_upscale_alpha_blend_top_tb.sv @@
// Testbench top for bilinear_upscale_alpha_blend_top: loads small images, streams
// blend words with random gaps and stalls, checks each result against the scoreboard.
// Depends on bua_pkg, bua_stream_if and bua_tb_pkg.
`timescale 1ns / 100ps
module bilinear_upscale_alpha_blend_top_tb;
    import bua_pkg::*;
    import bua_tb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    bua_stream_if #(.T(t_in_word))  in_ch ();
    bua_stream_if #(.T(t_out_word)) out_ch ();

    bilinear_upscale_alpha_blend_top dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .s_in      (in_ch.sink),
        .m_out     (out_ch.source),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    blend_scoreboard sb = new();
    int  cycles = 0;
    bit  long_stall = 1'b0;
    int  stall_max = 8;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        out_ch.ready = 1'b0;
    end

    // Cycle limit guards against a hung handshake.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("bilinear_upscale_alpha_blend_top_tb: FAIL");
            $finish;
        end
    end

    // Result side: checks every accepted word at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    end

    // Receiver: holds ready low for a random gap of up to stall_max before taking
    // each word, and holds off for a long stretch on request.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (long_stall) begin
                out_ch.ready = 1'b0;
                repeat (300) @(negedge i_clk);
                long_stall = 1'b0;
            end
            gap = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
            if (gap > 0) begin
                out_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            @(negedge i_clk);
        end
    end

    int send_gap_max = 8;

    // Sends one word after a random gap and waits for it to be accepted.
    task automatic send_word(t_in_word word);
        int gap;
        gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data  = word;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(word);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic load_pixel(int col, int row);
        t_in_word word;
        word.cmd = CMD_LOAD;
        word.col = COORD_BITS'(col);
        word.row = COORD_BITS'(row);
        {word.red_in, word.green_in, word.blue_in} = 24'($urandom);
        send_word(word);
    endtask

    task automatic blend_pixel(int col, int row);
        t_in_word word;
        word.cmd = CMD_BLEND;
        word.col = COORD_BITS'(col);
        word.row = COORD_BITS'(row);
        {word.red_in, word.green_in, word.blue_in} = 24'($urandom);
        send_word(word);
    endtask

    // Waits until all expected pixels are out, then past the pipeline.
    task automatic drain();
        while (sb.pending_pixels.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, int value);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = CFG_DATA_BITS'(value);
        @(posedge i_clk);
        sb.write_reg(idx, CFG_DATA_BITS'(value));
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_geometry(int w, int h, int cs, int rs, int bw);
        drain();
        write_cfg(CFG_SMALL_WIDTH, w);
        write_cfg(CFG_SMALL_HEIGHT, h);
        write_cfg(CFG_COL_STEP, cs);
        write_cfg(CFG_ROW_STEP, rs);
        write_cfg(CFG_BLEND_WEIGHT, bw);
    endtask

    // Random blend whose neighbors are loaded; large coordinates now and then.
    task automatic random_blend(int cmax, int rmax);
        int col, row;
        do begin
            if ($urandom_range(0, 15) == 0) begin
                col = $urandom_range(0, 4095);
                row = $urandom_range(0, 4095);
            end else begin
                col = $urandom_range(0, cmax);
                row = $urandom_range(0, rmax);
            end
        end while (!sb.blend_is_safe(COORD_BITS'(col), COORD_BITS'(row)));
        blend_pixel(col, row);
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: a 4x4 image, the right column and far corner at full size, and out-of-store loads.
        set_geometry(4, 4, 32768, 32768, 128);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) load_pixel(c, r);
        for (int r = 0; r < 4; r++) load_pixel(255, r);
        load_pixel(255, 255);
        load_pixel(4095, 0);
        load_pixel(0, 4095);
        blend_pixel(0, 0);
        blend_pixel(3, 5);
        blend_pixel(7, 7);
        blend_pixel(4095, 4095);
        set_geometry(0, 300, 65536, 0, 256);
        blend_pixel(0, 2);
        blend_pixel(4095, 1);
        set_geometry(511, 4, 131071, 21845, 0);
        blend_pixel(1, 3);
        blend_pixel(4095, 4095);
        set_geometry(4, 4, 21845, 43690, 511);
        blend_pixel(5, 5);
        blend_pixel(2, 1);

        // Random phases over several geometries; the image is reloaded each time.
        for (int phase = 0; phase < 5; phase++) begin
            int w, h;
            w = (phase == 4) ? 256 : $urandom_range(2, 9);
            h = (phase == 4) ? 1 : $urandom_range(1, 9);
            set_geometry(w, h, $urandom_range(0, 65536), $urandom_range(0, 65536),
                         $urandom_range(0, 256));
            for (int r = 0; r < h; r++)
                for (int c = 0; c < w; c++) load_pixel(c, r);
            if (phase == 1) begin
                send_gap_max = 0;
                stall_max = 0;
            end else begin
                send_gap_max = 8;
                stall_max = 8;
            end
            if (phase == 2) long_stall = 1'b1;
            for (int k = 0; k < 75; k++) begin
                if ($urandom_range(0, 9) == 0) load_pixel($urandom_range(0, 4095),
                                                          $urandom_range(256, 4095));
                else random_blend(2 * w + 2, 2 * h + 2);
                if (k == 37) drain();
            end
        end
        drain();
        if (sb.errors == 0 && sb.pending_pixels.size() == 0)
            $display("bilinear_upscale_alpha_blend_top_tb: PASS");
        else
            $display("bilinear_upscale_alpha_blend_top_tb: FAIL");
        $finish;
    end
endmodule

@@ files.f @@
hw/rtl/bua_pkg.sv
hw/rtl/bua_stream_if.sv
hw/rtl/bua_store.sv
hw/rtl/bilinear_upscale_alpha_blend_top.sv
tb/bua_tb_pkg.sv
tb/bilinear_upscale_alpha_blend_top_tb.sv
